@@ hw/rtl/chws_pkg.sv @@
// shared types and constants for the control history window statistics block
package chws_pkg;

  localparam int DATA_W    = 32;
  localparam int SUM_OUT_W = 40;
  localparam int WIN_W     = 7;
  localparam int FLAG_W    = 4;

  localparam int FL_MODE  = 0;
  localparam int FL_STEER = 1;
  localparam int FL_SPEED = 2;
  localparam int FL_STILL = 3;

  localparam logic [WIN_W-1:0] WIN_RESET = 7'd10;

  typedef logic signed [DATA_W-1:0] q_t;

  typedef struct packed {
    q_t                accel;
    q_t                curv;
    q_t                plan;
    q_t                lat;
    q_t                noise;
    q_t                meas;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  function automatic logic [DATA_W-1:0] mag32(q_t v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    return r;
  endfunction

endpackage

@@ hw/rtl/control_history_window_stats_top.sv @@
// top level: ring walk sequencer, statistics unit, mean divider and result register
// a transaction does one ring read per cycle over all DEPTH entries, then one quotient bit
// per cycle; the next sample is accepted only after the result is registered, later while the
// output is stalled; input stalls while a transaction is at work
// synchronous active-low reset clears the ring valid bits (entries read as zero),
// the newest slot, the window register (10) and all handshake state
module control_history_window_stats_top import chws_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [WIN_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  q_t                 in_accel_cmd,
  input  q_t                 in_curvature_cmd,
  input  q_t                 in_planner_accel,
  input  q_t                 in_lateral_error,
  input  q_t                 in_bus_noise_error,
  input  q_t                 in_measured_curvature,
  input  logic               in_auto_mode,
  input  logic               in_auto_steer,
  input  logic               in_auto_speed,
  input  logic               in_standstill,
  output logic               out_valid,
  input  logic               out_stall,
  output q_t                 out_max_accel,
  output q_t                 out_min_accel,
  output q_t                 out_max_curvature,
  output q_t                 out_min_curvature,
  output q_t                 out_min_planner_accel,
  output q_t                 out_least_abs_lateral,
  output logic signed [SUM_OUT_W-1:0] out_noise_error_sum,
  output q_t                 out_mean_curvature,
  output logic               out_always_auto_mode,
  output logic               out_always_auto_steer,
  output logic               out_always_auto_speed,
  output logic [WIN_W-1:0]   out_steps_since_standstill
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH+1);
  localparam int SUM_W = DATA_W + $clog2(DEPTH);
  localparam int EW    = SUM_W > SUM_OUT_W ? SUM_W : SUM_OUT_W;
  localparam logic signed [EW-1:0] LIM_HI = EW'($signed(40'h7F_FFFF_FFFF));
  localparam logic signed [EW-1:0] LIM_LO = EW'($signed(40'h80_0000_0000));

  typedef enum logic [1:0] {IDLE, WALK, DIV, DONE} state_t;

  state_t          state_r;
  logic [WIN_W-1:0] win_r;
  logic [AW-1:0]   newest_r;
  logic [AW-1:0]   newest_nxt;
  logic [AW-1:0]   rd_addr_r;
  logic [CW-1:0]   iss_r;
  logic [CW-1:0]   n_r;
  logic [CW-1:0]   n_eff;
  logic            pv_r;
  logic [CW-1:0]   pk_r;
  logic            accept;
  logic            issue;
  logic            div_start;
  logic            div_done;
  entry_t          in_entry;
  entry_t          rd_entry;

  q_t              mx_a, mn_a, mx_k, mn_k, mn_p, b_lat;
  logic signed [SUM_W-1:0] nsum, ksum, quot;
  logic            a_mode, a_steer, a_speed;
  logic [CW-1:0]   still;
  logic signed [EW-1:0] nsum_ext;

  assign in_stall = (state_r != IDLE);
  assign accept   = in_valid && !in_stall;
  assign issue    = (state_r == WALK) && (iss_r < CW'(DEPTH));
  assign div_start = (state_r == WALK) && (iss_r == CW'(DEPTH)) && !pv_r;

  assign newest_nxt = (newest_r == AW'(DEPTH-1)) ? '0 : newest_r + 1'b1;

  always_comb begin
    if (win_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(win_r) > 32'(DEPTH)) begin
      n_eff = CW'(DEPTH);
    end else begin
      n_eff = CW'(win_r);
    end
  end

  assign in_entry = '{accel: in_accel_cmd, curv: in_curvature_cmd,
                      plan: in_planner_accel, lat: in_lateral_error,
                      noise: in_bus_noise_error, meas: in_measured_curvature,
                      flags: {in_standstill, in_auto_speed, in_auto_steer, in_auto_mode}};

  chws_ring #(.DEPTH(DEPTH)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_addr (newest_nxt),
    .wr_data (in_entry),
    .rd_en   (issue),
    .rd_addr (rd_addr_r),
    .rd_data (rd_entry)
  );

  chws_acc #(.DEPTH(DEPTH)) u_acc (
    .clk        (clk),
    .seed       (accept),
    .seed_entry (in_entry),
    .step       (pv_r),
    .in_win     (pk_r < n_r),
    .k          (pk_r),
    .entry      (rd_entry),
    .max_accel  (mx_a),
    .min_accel  (mn_a),
    .max_curv   (mx_k),
    .min_curv   (mn_k),
    .min_plan   (mn_p),
    .best_lat   (b_lat),
    .nsum       (nsum),
    .ksum       (ksum),
    .all_mode   (a_mode),
    .all_steer  (a_steer),
    .all_speed  (a_speed),
    .still      (still)
  );

  chws_div #(.SUM_W(SUM_W), .DIV_W(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ksum),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (quot)
  );

  assign nsum_ext = EW'(nsum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      win_r     <= WIN_RESET;
      newest_r  <= '0;
      pv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (out_valid && !out_stall && state_r != DONE) begin
        out_valid <= 1'b0;
      end
      pv_r <= issue;
      if (issue) begin
        pk_r      <= iss_r;
        iss_r     <= iss_r + 1'b1;
        rd_addr_r <= (rd_addr_r == '0) ? AW'(DEPTH-1) : rd_addr_r - 1'b1;
      end
      unique case (state_r)
        IDLE: begin
          if (accept) begin
            newest_r  <= newest_nxt;
            rd_addr_r <= newest_nxt;
            iss_r     <= '0;
            n_r       <= n_eff;
            state_r   <= WALK;
          end
        end
        WALK: begin
          if (div_start) begin
            state_r <= DIV;
          end
        end
        DIV: begin
          if (div_done) begin
            state_r <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid                  <= 1'b1;
            out_max_accel              <= mx_a;
            out_min_accel              <= mn_a;
            out_max_curvature          <= mx_k;
            out_min_curvature          <= mn_k;
            out_min_planner_accel      <= mn_p;
            out_least_abs_lateral      <= b_lat;
            out_mean_curvature         <= DATA_W'(quot);
            out_always_auto_mode       <= a_mode;
            out_always_auto_steer      <= a_steer;
            out_always_auto_speed      <= a_speed;
            out_steps_since_standstill <= WIN_W'(still);
            if (nsum_ext > LIM_HI) begin
              out_noise_error_sum <= SUM_OUT_W'(LIM_HI);
            end else if (nsum_ext < LIM_LO) begin
              out_noise_error_sum <= SUM_OUT_W'(LIM_LO);
            end else begin
              out_noise_error_sum <= SUM_OUT_W'(nsum_ext);
            end
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/chws_ring.sv @@
// history ring memory with per-entry valid bits, one write and one registered read port
module chws_ring import chws_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  entry_t             rd_q_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

@@ hw/rtl/chws_acc.sv @@
// per-entry compare and accumulate unit for the window statistics
module chws_acc import chws_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             seed,
  input  entry_t                           seed_entry,
  input  logic                             step,
  input  logic                             in_win,
  input  logic [$clog2(DEPTH+1)-1:0]       k,
  input  entry_t                           entry,
  output q_t                               max_accel,
  output q_t                               min_accel,
  output q_t                               max_curv,
  output q_t                               min_curv,
  output q_t                               min_plan,
  output q_t                               best_lat,
  output logic signed [DATA_W+$clog2(DEPTH)-1:0] nsum,
  output logic signed [DATA_W+$clog2(DEPTH)-1:0] ksum,
  output logic                             all_mode,
  output logic                             all_steer,
  output logic                             all_speed,
  output logic [$clog2(DEPTH+1)-1:0]       still
);

  localparam int SUM_W = DATA_W + $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH+1);

  q_t                 mx_a_r, mn_a_r, mx_k_r, mn_k_r, mn_p_r, lat_r;
  logic [DATA_W-1:0]  mag_r;
  logic [DATA_W-1:0]  m;
  logic signed [SUM_W-1:0] nsum_r, ksum_r;
  logic               mode_r, steer_r, speed_r, found_r;
  logic [CW-1:0]      still_r;

  assign m = mag32(entry.lat);

  always_ff @(posedge clk) begin
    if (seed) begin
      mx_a_r  <= seed_entry.accel;
      mn_a_r  <= seed_entry.accel;
      mx_k_r  <= seed_entry.curv;
      mn_k_r  <= seed_entry.curv;
      mn_p_r  <= seed_entry.plan;
      lat_r   <= seed_entry.lat;
      mag_r   <= mag32(seed_entry.lat);
      nsum_r  <= '0;
      ksum_r  <= '0;
      mode_r  <= 1'b1;
      steer_r <= 1'b1;
      speed_r <= 1'b1;
      found_r <= 1'b0;
      still_r <= CW'(DEPTH);
    end else if (step) begin
      if (in_win) begin
        if (entry.flags[FL_STEER]) begin
          if (entry.accel > mx_a_r) mx_a_r <= entry.accel;
          if (entry.curv > mx_k_r) mx_k_r <= entry.curv;
          if (entry.curv < mn_k_r) mn_k_r <= entry.curv;
        end
        if (entry.flags[FL_SPEED] && entry.accel < mn_a_r) mn_a_r <= entry.accel;
        if (entry.plan < mn_p_r) mn_p_r <= entry.plan;
        if (m <= mag_r) begin
          mag_r <= m;
          lat_r <= entry.lat;
        end
        nsum_r <= nsum_r + SUM_W'(entry.noise);
        ksum_r <= ksum_r + SUM_W'(entry.meas);
        if (!entry.flags[FL_MODE])  mode_r  <= 1'b0;
        if (!entry.flags[FL_STEER]) steer_r <= 1'b0;
        if (!entry.flags[FL_SPEED]) speed_r <= 1'b0;
      end
      if (!found_r && entry.flags[FL_STILL]) begin
        found_r <= 1'b1;
        still_r <= k;
      end
    end
  end

  assign max_accel = mx_a_r;
  assign min_accel = mn_a_r;
  assign max_curv  = mx_k_r;
  assign min_curv  = mn_k_r;
  assign min_plan  = mn_p_r;
  assign best_lat  = lat_r;
  assign nsum      = nsum_r;
  assign ksum      = ksum_r;
  assign all_mode  = mode_r;
  assign all_steer = steer_r;
  assign all_speed = speed_r;
  assign still     = still_r;

endmodule

@@ hw/rtl/chws_div.sv @@
// bit-serial restoring divider, signed dividend by unsigned divisor, truncating
module chws_div #(
  parameter int SUM_W = 38,
  parameter int DIV_W = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int NW = $clog2(SUM_W+1);

  logic [SUM_W-1:0] q_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] d_r;
  logic [NW-1:0]    cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, q_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(SUM_W);
        q_r    <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        neg_r  <= dividend[SUM_W-1];
        rem_r  <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DIV_W'(trial - {1'b0, d_r}) : trial[DIV_W-1:0];
        q_r   <= {q_r[SUM_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

@@ bench/control_history_window_stats_checker.sv @@
// checker: predicts window statistics for each accepted sample and compares results
module control_history_window_stats_checker import chws_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [WIN_W-1:0]            cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  q_t                          in_accel_cmd,
  input  q_t                          in_curvature_cmd,
  input  q_t                          in_planner_accel,
  input  q_t                          in_lateral_error,
  input  q_t                          in_bus_noise_error,
  input  q_t                          in_measured_curvature,
  input  logic                        in_auto_mode,
  input  logic                        in_auto_steer,
  input  logic                        in_auto_speed,
  input  logic                        in_standstill,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  q_t                          out_max_accel,
  input  q_t                          out_min_accel,
  input  q_t                          out_max_curvature,
  input  q_t                          out_min_curvature,
  input  q_t                          out_min_planner_accel,
  input  q_t                          out_least_abs_lateral,
  input  logic signed [SUM_OUT_W-1:0] out_noise_error_sum,
  input  q_t                          out_mean_curvature,
  input  logic                        out_always_auto_mode,
  input  logic                        out_always_auto_steer,
  input  logic                        out_always_auto_speed,
  input  logic [WIN_W-1:0]            out_steps_since_standstill,
  output int                          fail_count,
  output int                          pending_stats,
  output int                          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    q_t                          max_a;
    q_t                          min_a;
    q_t                          max_k;
    q_t                          min_k;
    q_t                          min_p;
    q_t                          lat;
    logic signed [SUM_OUT_W-1:0] nsum;
    q_t                          mean;
    logic                        all_mode;
    logic                        all_steer;
    logic                        all_speed;
    logic [WIN_W-1:0]            still;
  } stats_t;

  entry_t           ring [DEPTH];
  int               head;
  logic [WIN_W-1:0] window_len;
  stats_t           expected_stats [$];

  function automatic logic [31:0] magnitude(q_t v);
    logic [32:0] w;
    w = v[31] ? -{v[31], v} : {1'b0, v};
    return w[31:0];
  endfunction

  function automatic stats_t window_stats();
    stats_t r;
    int n, idx;
    entry_t e, nw;
    logic [31:0] best_mag, m;
    longint nsum, ksum;
    nw = ring[head];
    n = window_len == 0 ? 1 : (window_len > DEPTH ? DEPTH : window_len);
    r.max_a = nw.accel; r.min_a = nw.accel;
    r.max_k = nw.curv;  r.min_k = nw.curv;
    r.min_p = nw.plan;  r.lat = nw.lat;
    best_mag = magnitude(nw.lat);
    nsum = 0; ksum = 0;
    r.all_mode = 1; r.all_steer = 1; r.all_speed = 1;
    for (int k = 0; k < n; k++) begin
      idx = (head + DEPTH - k) % DEPTH;
      e = ring[idx];
      m = magnitude(e.lat);
      if (e.flags[FL_STEER]) begin
        if (e.accel > r.max_a) r.max_a = e.accel;
        if (e.curv > r.max_k) r.max_k = e.curv;
        if (e.curv < r.min_k) r.min_k = e.curv;
      end
      if (e.flags[FL_SPEED] && e.accel < r.min_a) r.min_a = e.accel;
      if (e.plan < r.min_p) r.min_p = e.plan;
      if (m <= best_mag) begin
        best_mag = m;
        r.lat = e.lat;
      end
      nsum += longint'(e.noise);
      ksum += longint'(e.meas);
      if (!e.flags[FL_MODE]) r.all_mode = 0;
      if (!e.flags[FL_STEER]) r.all_steer = 0;
      if (!e.flags[FL_SPEED]) r.all_speed = 0;
    end
    r.still = WIN_W'(DEPTH);
    for (int k = 0; k < DEPTH; k++) begin
      if (ring[(head + DEPTH - k) % DEPTH].flags[FL_STILL]) begin
        r.still = WIN_W'(k);
        break;
      end
    end
    if (nsum > (64'sd1 <<< 39) - 1) nsum = (64'sd1 <<< 39) - 1;
    if (nsum < -(64'sd1 <<< 39)) nsum = -(64'sd1 <<< 39);
    r.nsum = nsum[SUM_OUT_W-1:0];
    ksum = ksum / longint'(n);
    r.mean = ksum[31:0];
    return r;
  endfunction

  task automatic report(string field, longint exp_v, longint act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on result %0d, %s: expected %0d actual %0d",
               result_count, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    stats_t e;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
      head = 0;
      window_len = WIN_RESET;
      expected_stats.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_wr_en) window_len = cfg_wr_data;
      if (in_valid && !in_stall) begin
        head = (head + 1) % DEPTH;
        ring[head] = '{in_accel_cmd, in_curvature_cmd, in_planner_accel, in_lateral_error,
                       in_bus_noise_error, in_measured_curvature,
                       {in_standstill, in_auto_speed, in_auto_steer, in_auto_mode}};
        expected_stats.insert(expected_stats.size(), window_stats());
      end
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          report("unexpected transaction", 0, 1);
        end else begin
          e = expected_stats.pop_front();
          if (out_max_accel !== e.max_a) report("max_accel", e.max_a, out_max_accel);
          if (out_min_accel !== e.min_a) report("min_accel", e.min_a, out_min_accel);
          if (out_max_curvature !== e.max_k)
            report("max_curvature", e.max_k, out_max_curvature);
          if (out_min_curvature !== e.min_k)
            report("min_curvature", e.min_k, out_min_curvature);
          if (out_min_planner_accel !== e.min_p)
            report("min_planner_accel", e.min_p, out_min_planner_accel);
          if (out_least_abs_lateral !== e.lat)
            report("least_abs_lateral", e.lat, out_least_abs_lateral);
          if (out_noise_error_sum !== e.nsum)
            report("noise_error_sum", e.nsum, out_noise_error_sum);
          if (out_mean_curvature !== e.mean)
            report("mean_curvature", e.mean, out_mean_curvature);
          if (out_always_auto_mode !== e.all_mode)
            report("always_auto_mode", e.all_mode, out_always_auto_mode);
          if (out_always_auto_steer !== e.all_steer)
            report("always_auto_steer", e.all_steer, out_always_auto_steer);
          if (out_always_auto_speed !== e.all_speed)
            report("always_auto_speed", e.all_speed, out_always_auto_speed);
          if (out_steps_since_standstill !== e.still)
            report("steps_since_standstill", e.still, out_steps_since_standstill);
        end
        result_count++;
      end
    end
    pending_stats = expected_stats.size();
  end

endmodule

@@ bench/control_history_window_stats_top_tb.sv @@
// testbench top: clock, reset, sample stimulus, window settings and verdict
module control_history_window_stats_top_tb import chws_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int LATENCY = 120;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [WIN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 0;
  logic in_stall;
  q_t in_accel_cmd = '0, in_curvature_cmd = '0, in_planner_accel = '0;
  q_t in_lateral_error = '0, in_bus_noise_error = '0, in_measured_curvature = '0;
  logic in_auto_mode = 0, in_auto_steer = 0, in_auto_speed = 0, in_standstill = 0;
  logic out_valid;
  logic out_stall = 0;
  q_t out_max_accel, out_min_accel, out_max_curvature, out_min_curvature;
  q_t out_min_planner_accel, out_least_abs_lateral, out_mean_curvature;
  logic signed [SUM_OUT_W-1:0] out_noise_error_sum;
  logic out_always_auto_mode, out_always_auto_steer, out_always_auto_speed;
  logic [WIN_W-1:0] out_steps_since_standstill;

  int fail_count, pending_stats, result_count;
  int samples_sent = 0;
  int hold_cycles = 0;
  int recv_wait = 0;
  bit random_gaps = 0;
  longint cycle_count = 0;

  always #5 clk = ~clk;

  control_history_window_stats_top #(.DEPTH(DEPTH)) u_top (.*);

  control_history_window_stats_checker #(.DEPTH(DEPTH)) u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random per-transaction wait, or a long hold when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else if (random_gaps && out_valid && recv_wait > 0) begin
      out_stall <= 1;
      recv_wait <= recv_wait - 1;
    end else begin
      out_stall <= 0;
      if (random_gaps && out_valid) recv_wait <= $urandom_range(0, 10);
    end
  end

  function automatic q_t rand_value(int mode);
    case (mode)
      0: return q_t'($urandom);
      1: return q_t'($urandom_range(0, 4)) - 2;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return q_t'($signed($urandom_range(0, 'h3ffff)) - 'h20000);
    endcase
  endfunction

  task automatic send_sample(q_t a, q_t c, q_t p, q_t l, q_t nz, q_t m, logic [3:0] fl);
    int gap;
    gap = random_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_accel_cmd <= a; in_curvature_cmd <= c; in_planner_accel <= p;
    in_lateral_error <= l; in_bus_noise_error <= nz; in_measured_curvature <= m;
    {in_standstill, in_auto_speed, in_auto_steer, in_auto_mode} <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_random();
    int md;
    logic [3:0] fl;
    md = $urandom_range(0, 3);
    fl = $urandom_range(0, 3) == 0 ? 4'($urandom) : {($urandom_range(0, 9) == 0), 3'b111};
    if ($urandom_range(0, 3) == 0) fl[2:0] = 3'($urandom);
    send_sample(rand_value(md), rand_value(md), rand_value(md), rand_value($urandom_range(0, 3)),
                rand_value($urandom_range(0, 3)), rand_value(md), fl);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_stats != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_window(logic [WIN_W-1:0] w);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  initial begin
    logic [WIN_W-1:0] windows [8] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd3, 7'd37, 7'd10};
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: reset window over zeroed ring, then extremes and ties
    send_sample('0, '0, '0, '0, '0, '0, 4'b0000);
    send_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                32'sh7fffffff, 32'sh7fffffff, 4'b0111);
    send_sample(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                32'sh7fffffff, 32'sh80000000, 4'b1111);
    send_sample(-5, 3, 1, 5, 32'sh7fffffff, -7, 4'b0110);
    send_sample(7, -3, 2, -5, 32'sh7fffffff, 7, 4'b0010);
    send_sample(1, 1, 1, 5, 32'sh80000000, -1, 4'b0100);
    set_window(7'd64);
    for (int i = 0; i < 70; i++)
      send_sample(32'sh7fffffff, i, -i, (i % 2) ? 3 : -3, 32'sh7fffffff,
                  32'sh7fffffff, 4'b0111);
    for (int i = 0; i < 8; i++)
      send_sample(32'sh80000000, -i, i, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, {i == 3, 3'b101});
    set_window(7'd0);
    send_sample(9, 9, 9, -9, 9, -9, 4'b1000);
    random_gaps = 1;
    foreach (windows[w]) begin
      set_window(windows[w]);
      for (int i = 0; i < 220; i++) send_random();
      if (w == 2) begin
        // long receiver hold while samples keep coming
        hold_cycles <= 600;
        for (int i = 0; i < 10; i++) send_random();
        drain();
      end
    end
    drain();
    $display("%0d samples sent, %0d results checked over windows 0..127 with idle gaps",
             samples_sent, result_count);
    if (fail_count == 0 && pending_stats == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/chws_pkg.sv
hw/rtl/chws_ring.sv
hw/rtl/chws_acc.sv
hw/rtl/chws_div.sv
hw/rtl/control_history_window_stats_top.sv
bench/control_history_window_stats_checker.sv
bench/control_history_window_stats_top_tb.sv
